### sv/line_table_dedup_delta_encoder_assert.svh
// Assertion macros for the line table encoder.
`ifndef LINE_TABLE_DEDUP_DELTA_ENCODER_ASSERT_SVH
`define LINE_TABLE_DEDUP_DELTA_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define LTDE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define LTDE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LTDE_ASSERT_IMP(lbl, ante, cons, msg)
`define LTDE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### sv/ltde_pkg.sv
// Shared types, constants and functions of the line table encoder.
package ltde_pkg;

  localparam int unsigned BLOCK_ENTRIES = 64;
  localparam int unsigned FILL_W        = $clog2(BLOCK_ENTRIES);
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QIDX_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned NVAL          = 3;

  // One kept entry: values to encode and block header data
  typedef struct packed {
    logic                       blk_begin;
    logic [31:0]                first_addr;
    logic [31:0]                byte_offset;
    logic [NVAL-1:0][VAL_W-1:0] val;
  } ltde_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ltde_qstat_t;

  function automatic logic [VAL_W-1:0] zigzag(input logic [VAL_W-1:0] d);
    zigzag = {d[VAL_W-2:0], 1'b0} ^ {VAL_W{d[VAL_W-1]}};
  endfunction

  // Bytes taken by the ULEB128 form of v
  function automatic logic [2:0] uleb_len(input logic [VAL_W-1:0] v);
    if (v[31:28] != '0)      uleb_len = 3'd5;
    else if (v[27:21] != '0) uleb_len = 3'd4;
    else if (v[20:14] != '0) uleb_len = 3'd3;
    else if (v[13:7] != '0)  uleb_len = 3'd2;
    else                     uleb_len = 3'd1;
  endfunction

endpackage

### sv/ltde_front.sv
// Front end: dedup, block tracking, delta and zigzag, byte position bookkeeping.
module ltde_front import ltde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] code_offset_i,
  input  logic [15:0] file_index_i,
  input  logic [30:0] line_number_i,
  input  logic        new_table_i,
  input  ltde_qstat_t q_stat_i,
  output logic        push_o,
  output ltde_entry_t push_data_o
);

  logic [31:0]       kept_off_q, kept_off_d, eff_off;
  logic [15:0]       kept_file_q, kept_file_d, eff_file;
  logic [30:0]       kept_line_q, kept_line_d, eff_line;
  logic              have_q, have_d, eff_have;
  logic [FILL_W-1:0] fill_q, fill_d, eff_fill;
  logic [31:0]       cnt_q, cnt_d, eff_cnt;
  logic              accept, drop, blk_begin;
  logic [31:0]       d_addr, zz_file, zz_line;
  logic [3:0]        nbytes;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    eff_off  = new_table_i ? '0 : kept_off_q;
    eff_file = new_table_i ? '0 : kept_file_q;
    eff_line = new_table_i ? '0 : kept_line_q;
    eff_have = new_table_i ? 1'b0 : have_q;
    eff_fill = new_table_i ? '0 : fill_q;
    eff_cnt  = new_table_i ? '0 : cnt_q;

    drop = eff_have && ((code_offset_i == eff_off) ||
                        ((file_index_i == eff_file) && (line_number_i == eff_line)));
    blk_begin = !eff_have || (eff_fill == '0);

    d_addr  = code_offset_i - eff_off;
    zz_file = zigzag({16'b0, file_index_i} - {16'b0, eff_file});
    zz_line = zigzag({1'b0, line_number_i} - {1'b0, eff_line});

    push_data_o.blk_begin   = blk_begin;
    push_data_o.first_addr  = code_offset_i;
    push_data_o.byte_offset = eff_cnt;
    if (blk_begin) begin
      push_data_o.val[0] = {16'b0, file_index_i};
      push_data_o.val[1] = {1'b0, line_number_i};
      push_data_o.val[2] = '0;
      nbytes = 4'(uleb_len({16'b0, file_index_i})) + 4'(uleb_len({1'b0, line_number_i}));
    end else begin
      push_data_o.val[0] = d_addr;
      push_data_o.val[1] = zz_file;
      push_data_o.val[2] = zz_line;
      nbytes = 4'(uleb_len(d_addr)) + 4'(uleb_len(zz_file)) + 4'(uleb_len(zz_line));
    end

    push_o = accept && !drop;

    kept_off_d  = kept_off_q;
    kept_file_d = kept_file_q;
    kept_line_d = kept_line_q;
    have_d      = have_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    if (accept) begin
      kept_off_d  = eff_off;
      kept_file_d = eff_file;
      kept_line_d = eff_line;
      have_d      = eff_have;
      fill_d      = eff_fill;
      cnt_d       = eff_cnt;
      if (!drop) begin
        kept_off_d  = code_offset_i;
        kept_file_d = file_index_i;
        kept_line_d = line_number_i;
        have_d      = 1'b1;
        cnt_d       = eff_cnt + 32'(nbytes);
        if (blk_begin) begin
          fill_d = FILL_W'(1);
        end else if (eff_fill == FILL_W'(BLOCK_ENTRIES - 1)) begin
          fill_d = '0;
        end else begin
          fill_d = eff_fill + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_off_q  <= '0;
      kept_file_q <= '0;
      kept_line_q <= '0;
      have_q      <= 1'b0;
      fill_q      <= '0;
      cnt_q       <= '0;
    end else begin
      kept_off_q  <= kept_off_d;
      kept_file_q <= kept_file_d;
      kept_line_q <= kept_line_d;
      have_q      <= have_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
    end
  end

endmodule

### sv/ltde_queue.sv
// Short queue of kept entries between front and back.
module ltde_queue import ltde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ltde_entry_t push_data_i,
  input  logic        pop_i,
  output ltde_entry_t head_o,
  output ltde_qstat_t stat_o
);

  ltde_entry_t       slot_q [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QIDX_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QIDX_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

### sv/ltde_back.sv
// Back end: ULEB128 byte serialiser with registered output.
module ltde_back import ltde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ltde_entry_t head_i,
  input  ltde_qstat_t q_stat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        block_begin_o,
  output logic [31:0] block_first_addr_o,
  output logic [31:0] block_byte_offset_o,
  output logic        last_byte_o
);

  logic             act_q, act_d;
  logic [VAL_W-1:0] cur_q, cur_d, nxt0_q, nxt0_d, nxt1_q, nxt1_d;
  logic [1:0]       rem_q, rem_d;
  logic             first_q, first_d, begin_q, begin_d;
  logic [31:0]      addr_q, addr_d, boff_q, boff_d;
  logic             ovalid_q, ovalid_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             obb_q, obb_d, olast_q, olast_d;
  logic [31:0]      oaddr_q, oaddr_d, oboff_q, oboff_d;
  logic             advance, more, entry_done, load;

  assign advance    = !ovalid_q || out_ready_i;
  assign more       = (cur_q[VAL_W-1:7] != '0);
  assign entry_done = act_q && !more && (rem_q == '0);
  assign load       = advance && (!act_q || entry_done) && !q_stat_i.empty;
  assign pop_o      = load;

  always_comb begin
    act_d    = act_q;
    cur_d    = cur_q;
    nxt0_d   = nxt0_q;
    nxt1_d   = nxt1_q;
    rem_d    = rem_q;
    first_d  = first_q;
    begin_d  = begin_q;
    addr_d   = addr_q;
    boff_d   = boff_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    obb_d    = obb_q;
    olast_d  = olast_q;
    oaddr_d  = oaddr_q;
    oboff_d  = oboff_q;

    if (advance) begin
      ovalid_d = act_q;
      if (act_q) begin
        obyte_d = {more, cur_q[6:0]};
        obb_d   = begin_q && first_q;
        oaddr_d = (begin_q && first_q) ? addr_q : '0;
        oboff_d = (begin_q && first_q) ? boff_q : '0;
        olast_d = entry_done;
        first_d = 1'b0;
        if (more) begin
          cur_d = cur_q >> 7;
        end else if (rem_q != '0) begin
          cur_d  = nxt0_q;
          nxt0_d = nxt1_q;
          rem_d  = rem_q - 2'd1;
        end else begin
          act_d = 1'b0;
        end
      end
    end

    if (load) begin
      act_d   = 1'b1;
      cur_d   = head_i.val[0];
      nxt0_d  = head_i.val[1];
      nxt1_d  = head_i.val[2];
      rem_d   = head_i.blk_begin ? 2'd1 : 2'd2;
      first_d = 1'b1;
      begin_d = head_i.blk_begin;
      addr_d  = head_i.first_addr;
      boff_d  = head_i.byte_offset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      act_q    <= act_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    nxt0_q  <= nxt0_d;
    nxt1_q  <= nxt1_d;
    rem_q   <= rem_d;
    first_q <= first_d;
    begin_q <= begin_d;
    addr_q  <= addr_d;
    boff_q  <= boff_d;
    obyte_q <= obyte_d;
    obb_q   <= obb_d;
    olast_q <= olast_d;
    oaddr_q <= oaddr_d;
    oboff_q <= oboff_d;
  end

  assign out_valid_o         = ovalid_q;
  assign out_byte_o          = obyte_q;
  assign block_begin_o       = obb_q;
  assign block_first_addr_o  = oaddr_q;
  assign block_byte_offset_o = oboff_q;
  assign last_byte_o         = olast_q;

endmodule

### sv/line_table_dedup_delta_encoder.sv
// Line table encoder top level: front end, entry queue, byte serialiser.
//
// Input channel (in_valid_i/in_ready_o) takes one address-to-line entry per
// item. Entries repeating the last kept offset, or its file and line, are
// dropped and cause no output. Kept entries are packed in blocks of
// BLOCK_ENTRIES: a block head gives ULEB128 file and line, later entries
// give ULEB128 address delta and zigzag file and line deltas.
// Output channel (out_valid_o/out_ready_i) carries one stream byte per item,
// with block_begin_o, block start address and byte offset on a block's first
// byte and last_byte_o on the final byte of each entry.
// Throughput: one output byte per cycle from the serialiser while out_ready_i
// is high; a kept entry gives 2 to 13 bytes and a dropped entry gives none.
// The front end takes an entry per cycle while the two-slot queue has room.
// Path: an accepted entry is written into a queue slot, loaded into the
// serialiser registers, and its first byte then goes to the output register.
// Reset clears front end state, queue pointers and count, act and output valid flags.
// When the receiver stalls the output byte holds; the queue fills and then
// in_ready_o drops until the serialiser moves on.
`include "line_table_dedup_delta_encoder_assert.svh"

module line_table_dedup_delta_encoder import ltde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] code_offset_i,
  input  logic [15:0] file_index_i,
  input  logic [30:0] line_number_i,
  input  logic        new_table_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        block_begin_o,
  output logic [31:0] block_first_addr_o,
  output logic [31:0] block_byte_offset_o,
  output logic        last_byte_o
);

  ltde_qstat_t q_stat;
  ltde_entry_t push_data, head;
  logic        push, pop;

  ltde_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .code_offset_i (code_offset_i),
    .file_index_i  (file_index_i),
    .line_number_i (line_number_i),
    .new_table_i   (new_table_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  ltde_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  ltde_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_i              (head),
    .q_stat_i            (q_stat),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_byte_o          (out_byte_o),
    .block_begin_o       (block_begin_o),
    .block_first_addr_o  (block_first_addr_o),
    .block_byte_offset_o (block_byte_offset_o),
    .last_byte_o         (last_byte_o)
  );

  `LTDE_ASSERT_IMP(a_no_push_when_full, push, !q_stat.full, "push into full queue")
  `LTDE_ASSERT_IMP(a_no_pop_when_empty, pop, !q_stat.empty, "pop from empty queue")
  `LTDE_ASSERT_NXT(a_entry_contiguous, out_valid_o && out_ready_i && !last_byte_o, out_valid_o, "gap inside an item's bytes")

endmodule

### verif/tb_top.sv
// Self-checking testbench for the line table dedup and delta encoder.
`timescale 1ns / 1ps

module tb_top;
  import ltde_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0]  data;
    logic        bgn;
    logic [31:0] addr;
    logic [31:0] boff;
    logic        last;
  } stream_byte_t;

  // n < 0: expectation from the predictor; otherwise bytes listed in b
  typedef struct packed {
    logic [31:0]      off;
    logic [15:0]      file;
    logic [30:0]      line;
    logic             nt;
    int               n;
    logic [0:7][7:0]  b;
    logic             bgn;
    logic [31:0]      boff;
  } entry_row_t;

  localparam int NUM_ROWS = 18;
  localparam entry_row_t ENTRY_ROWS [NUM_ROWS] = '{
    '{32'h0000_0000, 16'h0000, 31'h0000_0001, 1'b1,  2, 64'h0001_0000_0000_0000, 1'b1, 32'h0},
    '{32'h0000_0000, 16'h0001, 31'h0000_0002, 1'b0,  0, 64'h0,                   1'b0, 32'h0},
    '{32'h0000_0010, 16'h0000, 31'h0000_0001, 1'b0,  0, 64'h0,                   1'b0, 32'h0},
    '{32'h0000_0010, 16'h0000, 31'h0000_0002, 1'b0,  3, 64'h1000_0200_0000_0000, 1'b0, 32'h0},
    '{32'h0000_000F, 16'h0000, 31'h0000_0001, 1'b0, -1, 64'h0,                   1'b0, 32'h0},
    '{32'hFFFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF, 1'b0, -1, 64'h0,                   1'b0, 32'h0},
    '{32'h0000_0000, 16'h0000, 31'h0000_0000, 1'b0, -1, 64'h0,                   1'b0, 32'h0},
    '{32'h0000_0005, 16'hFFFF, 31'h7FFF_FFFF, 1'b1,  8, 64'hFFFF_03FF_FFFF_FF07, 1'b1, 32'h0},
    '{32'h0000_0006, 16'hFFFF, 31'h7FFF_FFFF, 1'b0,  0, 64'h0,                   1'b0, 32'h0},
    '{32'h0000_0007, 16'hFFFE, 31'h7FFF_FFFF, 1'b0,  3, 64'h0201_0000_0000_0000, 1'b0, 32'h0},
    '{32'h0000_0007, 16'h0000, 31'h0000_0000, 1'b1,  2, 64'h0000_0000_0000_0000, 1'b1, 32'h0},
    '{32'h0000_0007, 16'h0000, 31'h0000_0001, 1'b0,  0, 64'h0,                   1'b0, 32'h0},
    '{32'h0000_0080, 16'h0080, 31'h0000_4000, 1'b0, -1, 64'h0,                   1'b0, 32'h0},
    '{32'h0000_0080, 16'h0080, 31'h0000_4000, 1'b1,  5, 64'h8001_8080_0100_0000, 1'b1, 32'h0},
    '{32'h0000_1000, 16'h007F, 31'h0000_3FFF, 1'b0, -1, 64'h0,                   1'b0, 32'h0},
    '{32'h1000_0000, 16'h4000, 31'h0000_0001, 1'b0, -1, 64'h0,                   1'b0, 32'h0},
    '{32'h8000_0000, 16'h2AAA, 31'h5555_5555, 1'b0, -1, 64'h0,                   1'b0, 32'h0},
    '{32'hFFFF_FFFF, 16'h5555, 31'h2AAA_AAAA, 1'b0, -1, 64'h0,                   1'b0, 32'h0}
  };

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [31:0] code_offset_i = '0;
  logic [15:0] file_index_i  = '0;
  logic [30:0] line_number_i = '0;
  logic        new_table_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [7:0]  out_byte_o;
  logic        block_begin_o;
  logic [31:0] block_first_addr_o;
  logic [31:0] block_byte_offset_o;
  logic        last_byte_o;

  // predictor state
  logic [31:0] kept_off   = '0;
  logic [15:0] kept_file  = '0;
  logic [30:0] kept_line  = '0;
  bit          have_kept  = 1'b0;
  int          block_fill = 0;
  logic [31:0] byte_count = '0;

  stream_byte_t entry_bytes[$];
  stream_byte_t listed_bytes[$];
  stream_byte_t expected_bytes[$];
  stream_byte_t want;

  int mismatches  = 0;
  int cycle_count = 0;
  int send_idle   = 29;
  int recv_idle   = 51;
  bit hold_req    = 1'b0;
  int hold_count  = 0;

  line_table_dedup_delta_encoder DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .code_offset_i       (code_offset_i),
    .file_index_i        (file_index_i),
    .line_number_i       (line_number_i),
    .new_table_i         (new_table_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_byte_o          (out_byte_o),
    .block_begin_o       (block_begin_o),
    .block_first_addr_o  (block_first_addr_o),
    .block_byte_offset_o (block_byte_offset_o),
    .last_byte_o         (last_byte_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [31:0] zigzag_delta(input logic [31:0] a, input logic [31:0] b);
    if (a >= b) return (a - b) << 1;
    return ((b - a) << 1) - 32'd1;
  endfunction

  // bytes caused by one entry land in entry_bytes; state advances as the block's does
  function automatic void encode_entry(input logic [31:0] off, input logic [15:0] file,
                                       input logic [30:0] line, input logic nt);
    logic [31:0]  vals [3];
    logic [31:0]  v;
    int           nv;
    bit           bgn;
    stream_byte_t sb;
    entry_bytes.delete();
    if (nt) begin
      kept_off   = '0;
      kept_file  = '0;
      kept_line  = '0;
      have_kept  = 1'b0;
      block_fill = 0;
      byte_count = '0;
    end
    if (have_kept && (off == kept_off || (file == kept_file && line == kept_line))) return;
    bgn = !have_kept || block_fill == 0;
    if (bgn) begin
      block_fill = 0;
      vals[0] = {16'h0, file};
      vals[1] = {1'b0, line};
      nv = 2;
    end else begin
      vals[0] = off - kept_off;
      vals[1] = zigzag_delta({16'h0, file}, {16'h0, kept_file});
      vals[2] = zigzag_delta({1'b0, line}, {1'b0, kept_line});
      nv = 3;
    end
    for (int i = 0; i < nv; i++) begin
      v = vals[i];
      do begin
        sb = '0;
        sb.data = {1'b0, v[6:0]};
        v = v >> 7;
        sb.data[7] = (v != 0);
        entry_bytes.push_back(sb);
      end while (v != 0);
    end
    entry_bytes[0].bgn  = bgn;
    entry_bytes[0].addr = bgn ? off : '0;
    entry_bytes[0].boff = bgn ? byte_count : '0;
    entry_bytes[entry_bytes.size() - 1].last = 1'b1;
    byte_count += entry_bytes.size();
    kept_off   = off;
    kept_file  = file;
    kept_line  = line;
    have_kept  = 1'b1;
    block_fill++;
    if (block_fill >= BLOCK_ENTRIES) block_fill = 0;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_entry(input logic [31:0] off, input logic [15:0] file,
                            input logic [30:0] line, input logic nt, input bit listed);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    code_offset_i <= off;
    file_index_i  <= file;
    line_number_i <= line;
    new_table_i   <= nt;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    encode_entry(off, file, line, nt);
    if (listed) foreach (listed_bytes[k]) expected_bytes.push_back(listed_bytes[k]);
    else foreach (entry_bytes[k]) expected_bytes.push_back(entry_bytes[k]);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      out_ready_i <= 1'b0;
      hold_count  <= hold_count + 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: byte expected none actual %h", $time, out_byte_o);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        check_field("out_byte", {24'h0, want.data}, {24'h0, out_byte_o});
        check_field("block_begin", {31'h0, want.bgn}, {31'h0, block_begin_o});
        check_field("block_first_addr", want.addr, block_first_addr_o);
        check_field("block_byte_offset", want.boff, block_byte_offset_o);
        check_field("last_byte", {31'h0, want.last}, {31'h0, last_byte_o});
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    entry_row_t   row;
    stream_byte_t sb;
    logic [31:0]  r_off;
    logic [15:0]  r_file;
    logic [30:0]  r_line;
    logic         r_nt;
    int           pick;
    r_off  = '0;
    r_file = '0;
    r_line = 31'd1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle <= 51;
        recv_idle <= 29;
      end else if (phase == 2) begin
        send_idle <= 0;
        recv_idle <= 0;
        hold_req  <= 1'b1;
      end
      if (phase == 0) begin
        for (int i = 0; i < NUM_ROWS; i++) begin
          row = ENTRY_ROWS[i];
          listed_bytes.delete();
          for (int k = 0; k < row.n; k++) begin
            sb = '0;
            sb.data = row.b[k];
            if (k == 0 && row.bgn) begin
              sb.bgn  = 1'b1;
              sb.addr = row.off;
              sb.boff = row.boff;
            end
            sb.last = (k == row.n - 1);
            listed_bytes.push_back(sb);
          end
          send_entry(row.off, row.file, row.line, row.nt, row.n >= 0);
        end
      end
      for (int i = 0; i < 71; i++) begin
        r_nt = ($urandom_range(0, 99) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 5) r_off = r_off;
        else if (pick < 8) r_off = r_off - $urandom_range(1, 1000);
        else if (pick < 12) r_off = $urandom();
        else if (pick < 20) r_off = r_off + $urandom_range(1, 1 << 20);
        else r_off = r_off + $urandom_range(1, 300);
        pick = $urandom_range(0, 99);
        if (pick < 85) r_file = (pick < 70) ? r_file : 16'($urandom_range(0, 15));
        else r_file = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 6) r_line = r_line;
        else if (pick < 60) r_line = r_line + 31'($urandom_range(1, 20));
        else if (pick < 78) r_line = r_line - 31'($urandom_range(1, 20));
        else if (pick < 93) r_line = 31'($urandom_range(1, 5000));
        else if (pick < 95) r_line = '0;
        else r_line = 31'($urandom());
        send_entry(r_off, r_file, r_line, r_nt, 1'b0);
      end
    end
    in_valid_i <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/ltde_pkg.sv
sv/ltde_front.sv
sv/ltde_queue.sv
sv/ltde_back.sv
sv/line_table_dedup_delta_encoder.sv
verif/tb_top.sv
